FILE: hdl/reader_writer_lock_arbiter_top_macros.svh
// Assertion macros shared by the reader-writer lock arbiter RTL.
`ifndef READER_WRITER_LOCK_ARBITER_TOP_MACROS_SVH
`define READER_WRITER_LOCK_ARBITER_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
// Clocked check, off while reset is asserted.
`define RWLA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Clocked check that also holds during reset.
`define RWLA_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define RWLA_ASSERT(lbl, prop, msg)
`define RWLA_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

FILE: hdl/rwla_pkg.sv
// Package with opcodes and default sizes for the reader-writer lock arbiter.
`timescale 1ns / 1ps
package rwla_pkg;

    localparam int OPCODE_W = 2;

    localparam int MAX_READERS_DEF        = 1024;
    localparam int WRITER_QUEUE_DEPTH_DEF = 16;
    localparam int ID_WIDTH_DEF           = 8;

    typedef enum logic [OPCODE_W-1:0] {
        OP_ENTER_READ  = 2'd0,
        OP_LEAVE_READ  = 2'd1,
        OP_ENTER_WRITE = 2'd2,
        OP_LEAVE_WRITE = 2'd3
    } op_t;

endpackage

FILE: hdl/rwla_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module rwla_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Read returns the contents from before a write at the same edge.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: hdl/reader_writer_lock_arbiter_top.sv
// Reader-writer lock arbiter, writer preferring, one request per transfer.
// Usage:
//   Requests come in on the s_axis channel: s_axis_tuser carries the opcode
//   (enter read, leave read, enter write, leave write), s_axis_tdata the
//   requester id. Each request gives exactly one result transfer on m_axis:
//   grant flag, number of queued readers released, id of the queued writer
//   made owner (0 if none) and an error flag. Misuse and overflow set error
//   and leave the lock state untouched.
//   A request passes the input register and then the result register on
//   its way to m_axis; one request per cycle is sustained while m_axis is
//   ready, with the single state update stage between those two registers.
//   Waiting writer ids sit in a RAM FIFO; the head id is kept in a register
//   with the next entry prefetched, so consecutive hand-offs need no bubble.
//   After reset the lock is free with no waiters and no owner; no clearing
//   pass is needed, so requests are taken at once.
//   When m_axis_tready is low the result register holds and the input stage
//   fills; s_axis_tready then drops until the receiver takes a transfer.
`timescale 1ns / 1ps
`include "reader_writer_lock_arbiter_top_macros.svh"
module reader_writer_lock_arbiter_top #(
    parameter int MAX_READERS        = rwla_pkg::MAX_READERS_DEF,
    parameter int WRITER_QUEUE_DEPTH = rwla_pkg::WRITER_QUEUE_DEPTH_DEF,
    parameter int ID_WIDTH           = rwla_pkg::ID_WIDTH_DEF,
    parameter int RW                 = $clog2(MAX_READERS + 1),
    parameter int IN_W               = ((ID_WIDTH + 7) / 8) * 8,
    parameter int OUT_W              = ((RW + ID_WIDTH + 2 + 7) / 8) * 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // [ID_WIDTH-1:0] requester_id
    input  logic [IN_W-1:0]               s_axis_tdata,
    // [1:0] opcode
    input  logic [rwla_pkg::OPCODE_W-1:0] s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // [0] enter_granted, [RW:1] readers_woken,
    // [RW+ID_WIDTH:RW+1] writer_woken_id, [RW+ID_WIDTH+1] error
    output logic [OUT_W-1:0]              m_axis_tdata
);

    import rwla_pkg::*;

    localparam int HW = RW + 1;
    localparam int WW = $clog2(WRITER_QUEUE_DEPTH + 1);
    localparam int AW = (WRITER_QUEUE_DEPTH > 1) ? $clog2(WRITER_QUEUE_DEPTH) : 1;

    localparam logic signed [HW-1:0] HOLD_MAX = HW'(MAX_READERS);
    localparam logic signed [HW-1:0] HOLD_MIN = -HOLD_MAX;
    localparam logic signed [HW-1:0] HOLD_ONE = HW'(1);
    localparam logic signed [HW-1:0] HOLD_NEG_ONE = '1;
    localparam logic [AW-1:0]        PTR_LAST = AW'(WRITER_QUEUE_DEPTH - 1);
    localparam logic [AW:0]          DEPTH_EXT = (AW + 1)'(WRITER_QUEUE_DEPTH);

    // input stage
    logic                in_valid_reg;
    op_t                 in_op_reg;
    logic [ID_WIDTH-1:0] in_id_reg;

    // lock state
    logic signed [HW-1:0] hold_reg, hold_next;
    logic [RW-1:0]        rwait_reg, rwait_next;
    logic [WW-1:0]        wwait_reg, wwait_next;
    logic [ID_WIDTH-1:0]  owner_reg, owner_next;
    logic [AW-1:0]        head_reg, head_next;
    logic [ID_WIDTH-1:0]  head_id_reg, head_id_next;
    logic                 fwd_hit_reg, fwd_hit_next;
    logic [ID_WIDTH-1:0]  fwd_data_reg;

    // result stage
    logic                out_valid_reg;
    logic                out_granted_reg, out_granted_next;
    logic [RW-1:0]       out_rwoken_reg, out_rwoken_next;
    logic [ID_WIDTH-1:0] out_wid_reg, out_wid_next;
    logic                out_err_reg, out_err_next;

    logic                advance;
    logic                fire;
    logic                push;
    logic                pop;
    logic                hold_neg;
    logic                hold_pos;
    logic                ww_nz;
    logic [AW:0]         tail_sum;
    logic [AW-1:0]       tail;
    logic [AW-1:0]       ram_raddr;
    logic [ID_WIDTH-1:0] ram_rdata;
    logic [ID_WIDTH-1:0] second_id;

    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] ptr);
        logic [AW-1:0] res;
        if (ptr == PTR_LAST)
        begin
            res = '0;
        end
        else
        begin
            res = ptr + AW'(1);
        end
        return res;
    endfunction

    assign advance       = !out_valid_reg || m_axis_tready;
    assign fire          = in_valid_reg && advance;
    assign s_axis_tready = !in_valid_reg || advance;

    assign hold_neg = hold_reg[HW-1];
    assign hold_pos = !hold_reg[HW-1] && (hold_reg != '0);
    assign ww_nz    = (wwait_reg != '0);

    assign tail_sum = (AW + 1)'(head_reg) + (AW + 1)'(wwait_reg);
    assign tail     = (tail_sum >= DEPTH_EXT) ? AW'(tail_sum - DEPTH_EXT) : AW'(tail_sum);

    // entry behind the head, patched with a write made in the previous cycle
    assign second_id = fwd_hit_reg ? fwd_data_reg : ram_rdata;

    always_comb
    begin
        hold_next        = hold_reg;
        rwait_next       = rwait_reg;
        wwait_next       = wwait_reg;
        owner_next       = owner_reg;
        head_next        = head_reg;
        head_id_next     = head_id_reg;
        out_granted_next = 1'b0;
        out_rwoken_next  = '0;
        out_wid_next     = '0;
        out_err_next     = 1'b0;
        push             = 1'b0;
        pop              = 1'b0;

        if (fire)
        begin
            unique case (in_op_reg)
                OP_ENTER_READ:
                begin
                    if (hold_neg || ww_nz)
                    begin
                        if (rwait_reg >= RW'(MAX_READERS))
                        begin
                            out_err_next = 1'b1;
                        end
                        else
                        begin
                            rwait_next = rwait_reg + RW'(1);
                        end
                    end
                    else if (hold_reg >= HOLD_MAX)
                    begin
                        out_err_next = 1'b1;
                    end
                    else
                    begin
                        hold_next        = hold_reg + HOLD_ONE;
                        out_granted_next = 1'b1;
                    end
                end
                OP_LEAVE_READ:
                begin
                    if (!hold_pos)
                    begin
                        out_err_next = 1'b1;
                    end
                    else
                    begin
                        hold_next = hold_reg - HOLD_ONE;
                        // last reader out hands over to the head writer
                        if (hold_reg == HOLD_ONE && ww_nz)
                        begin
                            pop = 1'b1;
                        end
                    end
                end
                OP_ENTER_WRITE:
                begin
                    if (in_id_reg == '0)
                    begin
                        out_err_next = 1'b1;
                    end
                    else if (hold_reg == '0)
                    begin
                        owner_next       = in_id_reg;
                        hold_next        = HOLD_NEG_ONE;
                        out_granted_next = 1'b1;
                    end
                    else if (hold_neg && owner_reg == in_id_reg)
                    begin
                        if (hold_reg <= HOLD_MIN)
                        begin
                            out_err_next = 1'b1;
                        end
                        else
                        begin
                            hold_next        = hold_reg - HOLD_ONE;
                            out_granted_next = 1'b1;
                        end
                    end
                    else if (wwait_reg >= WW'(WRITER_QUEUE_DEPTH))
                    begin
                        out_err_next = 1'b1;
                    end
                    else
                    begin
                        push = 1'b1;
                    end
                end
                OP_LEAVE_WRITE:
                begin
                    if (in_id_reg == '0 || !hold_neg || owner_reg != in_id_reg)
                    begin
                        out_err_next = 1'b1;
                    end
                    else
                    begin
                        hold_next = hold_reg + HOLD_ONE;
                        if (hold_reg == HOLD_NEG_ONE)
                        begin
                            owner_next = '0;
                            // writers first, else release every queued reader
                            if (ww_nz)
                            begin
                                pop = 1'b1;
                            end
                            else if (rwait_reg != '0)
                            begin
                                hold_next       = HW'(rwait_reg);
                                out_rwoken_next = rwait_reg;
                                rwait_next      = '0;
                            end
                        end
                    end
                end
                default:
                begin
                    out_err_next = 1'b1;
                end
            endcase

            if (pop)
            begin
                out_wid_next = head_id_reg;
                owner_next   = head_id_reg;
                hold_next    = HOLD_NEG_ONE;
                wwait_next   = wwait_reg - WW'(1);
                head_next    = ptr_inc(head_reg);
                head_id_next = second_id;
            end

            if (push)
            begin
                wwait_next = wwait_reg + WW'(1);
                if (!ww_nz)
                begin
                    head_id_next = in_id_reg;
                end
            end
        end
    end

    // prefetch the entry behind the next head
    assign ram_raddr    = ptr_inc(head_next);
    assign fwd_hit_next = push && (tail == ram_raddr);

    rwla_ram #(
        .WIDTH (ID_WIDTH),
        .DEPTH (WRITER_QUEUE_DEPTH),
        .AW    (AW)
    ) u_wq_ram (
        .clk   (clk),
        .we    (push),
        .waddr (tail),
        .wdata (in_id_reg),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            hold_reg      <= '0;
            rwait_reg     <= '0;
            wwait_reg     <= '0;
            owner_reg     <= '0;
            head_reg      <= '0;
            fwd_hit_reg   <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
            hold_reg    <= hold_next;
            rwait_reg   <= rwait_next;
            wwait_reg   <= wwait_next;
            owner_reg   <= owner_next;
            head_reg    <= head_next;
            fwd_hit_reg <= fwd_hit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_op_reg <= op_t'(s_axis_tuser);
            in_id_reg <= s_axis_tdata[ID_WIDTH-1:0];
        end
        if (fire)
        begin
            out_granted_reg <= out_granted_next;
            out_rwoken_reg  <= out_rwoken_next;
            out_wid_reg     <= out_wid_next;
            out_err_reg     <= out_err_next;
        end
        head_id_reg  <= head_id_next;
        fwd_data_reg <= in_id_reg;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_W'({out_err_reg, out_wid_reg, out_rwoken_reg, out_granted_reg});

    `RWLA_ASSERT(a_hold_range, (hold_reg <= HOLD_MAX) && (hold_reg >= HOLD_MIN), "hold count out of range")
    `RWLA_ASSERT(a_owner_iff_write, hold_neg == (owner_reg != '0), "owner id disagrees with write hold")
    `RWLA_ASSERT(a_readers_blocked, (rwait_reg != '0) |-> (hold_neg || ww_nz), "readers wait on a lock they could take")
    `RWLA_ASSERT(a_wq_bound, wwait_reg <= WW'(WRITER_QUEUE_DEPTH), "writer queue count overflow")

endmodule

FILE: bench/reader_writer_lock_arbiter_top_test.sv
// Testbench for the reader-writer lock arbiter: lock requests checked against a predictor.
`timescale 1ns / 1ps
module reader_writer_lock_arbiter_top_test;
    import rwla_pkg::*;

    localparam int MAX_RD    = MAX_READERS_DEF;
    localparam int WQ_DEPTH  = WRITER_QUEUE_DEPTH_DEF;
    localparam int RD_W      = $clog2(MAX_RD + 1);
    localparam int ID_W      = ID_WIDTH_DEF;
    localparam int IN_W      = ((ID_W + 7) / 8) * 8;
    localparam int OUT_W     = ((RD_W + ID_W + 2 + 7) / 8) * 8;
    localparam int N_RANDOM  = 800;

    localparam logic [ID_W-1:0] ID_POOL [8] = '{
        8'h01, 8'h02, 8'h80, 8'hFF, 8'h5A, 8'hA5, 8'h33, 8'hCC
    };

    typedef struct {
        logic            granted;
        logic [RD_W-1:0] readers_woken;
        logic [ID_W-1:0] writer_woken_id;
        logic            error;
    } lock_outcome_t;

    class lock_scoreboard;
        int              hold_count;
        int              waiting_readers;
        logic [ID_W-1:0] owner_id;
        logic [ID_W-1:0] writer_fifo[$];
        lock_outcome_t   pending_outcomes[$];
        int unsigned     mismatches;

        function new();
            hold_count      = 0;
            waiting_readers = 0;
            owner_id        = '0;
            mismatches      = 0;
        endfunction

        function logic [ID_W-1:0] hand_to_head_writer();
            logic [ID_W-1:0] id;
            id         = writer_fifo.pop_front();
            owner_id   = id;
            hold_count = -1;
            return id;
        endfunction

        function lock_outcome_t predict_lock_outcome(op_t op, logic [ID_W-1:0] id);
            lock_outcome_t o;
            o = '{granted: 1'b0, readers_woken: '0, writer_woken_id: '0, error: 1'b0};
            case (op)
                OP_ENTER_READ:
                begin
                    // Queue behind a writer that owns the lock or waits for it.
                    if (hold_count < 0 || writer_fifo.size() > 0)
                    begin
                        if (waiting_readers >= MAX_RD)
                            o.error = 1'b1;
                        else
                            waiting_readers++;
                    end
                    else if (hold_count >= MAX_RD)
                        o.error = 1'b1;
                    else
                    begin
                        hold_count++;
                        o.granted = 1'b1;
                    end
                end
                OP_LEAVE_READ:
                begin
                    if (hold_count <= 0)
                        o.error = 1'b1;
                    else
                    begin
                        hold_count--;
                        if (hold_count == 0 && writer_fifo.size() > 0)
                            o.writer_woken_id = hand_to_head_writer();
                    end
                end
                OP_ENTER_WRITE:
                begin
                    if (id == '0)
                        o.error = 1'b1;
                    else if (hold_count == 0)
                    begin
                        owner_id   = id;
                        hold_count = -1;
                        o.granted  = 1'b1;
                    end
                    else if (hold_count < 0 && owner_id == id)
                    begin
                        if (hold_count <= -MAX_RD)
                            o.error = 1'b1;
                        else
                        begin
                            hold_count--;
                            o.granted = 1'b1;
                        end
                    end
                    else if (writer_fifo.size() >= WQ_DEPTH)
                        o.error = 1'b1;
                    else
                        writer_fifo.push_back(id);
                end
                default:
                begin
                    if (id == '0 || hold_count >= 0 || owner_id != id)
                        o.error = 1'b1;
                    else
                    begin
                        hold_count++;
                        if (hold_count == 0)
                        begin
                            owner_id = '0;
                            // Prefer a waiting writer; otherwise release every queued reader.
                            if (writer_fifo.size() > 0)
                                o.writer_woken_id = hand_to_head_writer();
                            else if (waiting_readers > 0)
                            begin
                                hold_count      = waiting_readers;
                                o.readers_woken = RD_W'(waiting_readers);
                                waiting_readers = 0;
                            end
                        end
                    end
                end
            endcase
            return o;
        endfunction

        function void note_request(op_t op, logic [ID_W-1:0] id);
            pending_outcomes.push_back(predict_lock_outcome(op, id));
        endfunction

        function void check_result(logic [OUT_W-1:0] data);
            lock_outcome_t want;
            lock_outcome_t got;
            got.granted         = data[0];
            got.readers_woken   = data[RD_W:1];
            got.writer_woken_id = data[RD_W+ID_W:RD_W+1];
            got.error           = data[RD_W+ID_W+1];
            if (pending_outcomes.size() == 0)
            begin
                $display("%0t: result with nothing outstanding, expected none, got %h",
                         $time, data);
                mismatches++;
                return;
            end
            want = pending_outcomes.pop_front();
            if (got.granted !== want.granted)
            begin
                $display("%0t: enter_granted expected %0d, got %0d",
                         $time, want.granted, got.granted);
                mismatches++;
            end
            if (got.readers_woken !== want.readers_woken)
            begin
                $display("%0t: readers_woken expected %0d, got %0d",
                         $time, want.readers_woken, got.readers_woken);
                mismatches++;
            end
            if (got.writer_woken_id !== want.writer_woken_id)
            begin
                $display("%0t: writer_woken_id expected %0d, got %0d",
                         $time, want.writer_woken_id, got.writer_woken_id);
                mismatches++;
            end
            if (got.error !== want.error)
            begin
                $display("%0t: error expected %0d, got %0d",
                         $time, want.error, got.error);
                mismatches++;
            end
        endfunction
    endclass

    logic                clk           = 1'b0;
    logic                rst_n         = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [IN_W-1:0]     s_axis_tdata  = '0;
    logic [OPCODE_W-1:0] s_axis_tuser  = OP_ENTER_READ;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [OUT_W-1:0]    m_axis_tdata;

    lock_scoreboard lock_sb = new();
    int             burst_left = 0;
    int             stall_run  = 0;
    int             stall_mode = 0;
    logic [2:0]     stall_phase = '0;

    reader_writer_lock_arbiter_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // [7:0] requester_id
        .s_axis_tuser  (s_axis_tuser),   // [1:0] opcode
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        // [0] enter_granted, [11:1] readers_woken, [19:12] writer_woken_id, [20] error
        .m_axis_tdata  (m_axis_tdata)
    );

    always #1 clk = ~clk;

    // Receiver: switch among always ready, coin flip, rare stalls and a fixed stall pattern.
    always @(posedge clk)
    begin
        stall_phase <= stall_phase + 3'd1;
        if (stall_run == 0)
        begin
            stall_mode <= $urandom_range(0, 3);
            stall_run  <= $urandom_range(32, 256);
        end
        else
            stall_run <= stall_run - 1;
        case (stall_mode)
            0:       m_axis_tready <= 1'b1;
            1:       m_axis_tready <= 1'($urandom_range(0, 1));
            2:       m_axis_tready <= ($urandom_range(0, 15) != 0);
            default: m_axis_tready <= (stall_phase < 3'd5);
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            lock_sb.check_result(m_axis_tdata);
    end

    task automatic send_request(input op_t op, input logic [ID_W-1:0] id);
        if (burst_left == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
            burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 24);
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= id;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        lock_sb.note_request(op, id);
    endtask

    task automatic wait_for_results();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (lock_sb.pending_outcomes.size() != 0)
            @(posedge clk);
    endtask

    // Release holds until the lock is free; hand-offs drain the queues on the way.
    task automatic drain_lock();
        while (lock_sb.hold_count != 0)
        begin
            if (lock_sb.hold_count > 0)
                send_request(OP_LEAVE_READ, ID_W'($urandom_range(0, 255)));
            else
                send_request(OP_LEAVE_WRITE, lock_sb.owner_id);
        end
    endtask

    task automatic random_request();
        op_t             op;
        logic [ID_W-1:0] id;
        int              pick;
        pick = $urandom_range(0, 9);
        id   = ID_POOL[$urandom_range(0, 7)];
        if ($urandom_range(0, 99) < 15)
        begin
            op = op_t'($urandom_range(0, 3));
            id = ID_W'($urandom_range(0, 255));
        end
        else if (lock_sb.hold_count < 0)
        begin
            if (pick < 4)
            begin
                op = OP_LEAVE_WRITE;
                id = lock_sb.owner_id;
            end
            else if (pick == 4)
            begin
                op = OP_ENTER_WRITE;
                id = lock_sb.owner_id;
            end
            else if (pick < 7)
                op = OP_ENTER_WRITE;
            else
                op = OP_ENTER_READ;
        end
        else if (lock_sb.hold_count > 0)
            op = (pick < 4) ? OP_LEAVE_READ : (pick < 7) ? OP_ENTER_READ : OP_ENTER_WRITE;
        else
            op = (pick < 6) ? OP_ENTER_READ : OP_ENTER_WRITE;
        send_request(op, id);
    endtask

    initial
    begin
        logic [ID_W-1:0] owner;
        logic [ID_W-1:0] other;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Misuse on a free lock, then readers, queued writers, nesting and hand-offs.
        send_request(OP_LEAVE_READ, 8'd0);
        send_request(OP_LEAVE_WRITE, 8'd5);
        send_request(OP_ENTER_WRITE, 8'd0);
        send_request(OP_LEAVE_WRITE, 8'd0);
        send_request(OP_ENTER_READ, 8'd0);
        send_request(OP_ENTER_READ, 8'd255);
        send_request(OP_ENTER_WRITE, 8'd1);
        send_request(OP_ENTER_READ, 8'd7);
        send_request(OP_LEAVE_READ, 8'd0);
        send_request(OP_LEAVE_READ, 8'd255);
        send_request(OP_ENTER_WRITE, 8'd1);
        send_request(OP_ENTER_READ, 8'd1);
        send_request(OP_LEAVE_WRITE, 8'd2);
        send_request(OP_LEAVE_WRITE, 8'd1);
        send_request(OP_ENTER_WRITE, 8'd255);
        send_request(OP_LEAVE_WRITE, 8'd1);
        send_request(OP_LEAVE_WRITE, 8'd255);
        send_request(OP_LEAVE_READ, 8'd7);
        send_request(OP_LEAVE_READ, 8'd1);
        send_request(OP_ENTER_WRITE, 8'd170);
        send_request(OP_ENTER_WRITE, 8'd85);
        send_request(OP_LEAVE_WRITE, 8'd170);
        send_request(OP_LEAVE_WRITE, 8'd85);
        drain_lock();
        wait_for_results();

        // Reader count full, then one leave read too many.
        repeat (MAX_RD + 1) send_request(OP_ENTER_READ, ID_W'($urandom_range(0, 255)));
        repeat (MAX_RD + 1) send_request(OP_LEAVE_READ, ID_W'($urandom_range(0, 255)));

        // Queued readers full, then release them all at once.
        owner = ID_W'($urandom_range(1, 255));
        send_request(OP_ENTER_WRITE, owner);
        repeat (MAX_RD + 1) send_request(OP_ENTER_READ, ID_W'($urandom_range(0, 255)));
        send_request(OP_LEAVE_WRITE, owner);
        drain_lock();
        wait_for_results();

        // Write nesting full, unwind, then a leave write with no hold.
        owner = ID_W'($urandom_range(1, 255));
        repeat (MAX_RD + 1) send_request(OP_ENTER_WRITE, owner);
        drain_lock();
        send_request(OP_LEAVE_WRITE, owner);

        // Writer queue full, then hand the lock down the queue.
        owner = ID_W'($urandom_range(1, 255));
        send_request(OP_ENTER_WRITE, owner);
        repeat (WQ_DEPTH + 1)
        begin
            do
                other = ID_W'($urandom_range(1, 255));
            while (other == owner);
            send_request(OP_ENTER_WRITE, other);
        end
        drain_lock();
        wait_for_results();

        for (int n = 0; n < N_RANDOM; n++)
        begin
            random_request();
            if (n == N_RANDOM / 2)
                wait_for_results();
        end
        drain_lock();
        wait_for_results();
        repeat (8) @(posedge clk);

        if (lock_sb.mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+hdl
hdl/rwla_pkg.sv
hdl/rwla_ram.sv
hdl/reader_writer_lock_arbiter_top.sv
bench/reader_writer_lock_arbiter_top_test.sv
